// ----- rtl/x86sr_pkg.sv -----
// ----------------------------------------------------------------------------
// x86sr_pkg: shared types and codes for the shift/rotate unit
// Operation codes, request and result structs, and the reduced-count bundle
// passed from the count reducer to the datapath.
// ----------------------------------------------------------------------------
package x86sr_pkg;

  typedef enum logic [2:0] {
    OP_ROL  = 3'd0,
    OP_ROR  = 3'd1,
    OP_RCL  = 3'd2,
    OP_RCR  = 3'd3,
    OP_SHL  = 3'd4,
    OP_SHR  = 3'd5,
    OP_NONE = 3'd6,
    OP_SAR  = 3'd7
  } op_t;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 16;

  typedef struct packed {
    logic [2:0]  op;
    logic        wide;
    logic [15:0] value;
    logic [7:0]  count;
    logic        carry_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        writes_back;
    logic        co_valid;
    logic        carry_out;
    logic        overflow_out;
    logic        szp_valid;
    logic        sign_out;
    logic        zero_out;
    logic        parity_out;
  } out_item_t;

  // Count forms needed by the datapath
  typedef struct packed {
    logic [3:0] rot_r;   // count mod width
    logic [4:0] rc_r;    // count mod (width + 1)
    logic [4:0] sh_amt;  // count clamped to width + 1
    logic       is_zero;
    logic       is_one;
  } cnt_t;

endpackage

// ----- rtl/x86_shift_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// x86_shift_rotate_unit: 8086 group-2 shift and rotate unit
// Two-stage registered unit: request register, combinational count reducer
// and shift/rotate datapath, result register.
//
//   channel | direction | ports                          | accept when
//   --------+-----------+--------------------------------+--------------------
//   request | in        | in_valid, in_stall, in_data    | in_valid & !in_stall
//   result  | out       | out_valid, out_stall, out_data | out_valid & !out_stall
//
// One request per cycle sustained while out_stall is low. An accepted request
// is held in the request register, then passes through the count reducer and
// datapath into the result register, which drives out_valid and out_data.
// Reset (rst_n low, synchronous) empties both stages.
// out_stall holds the result register; the request register keeps filling
// until both stages are full, then in_stall rises in the same cycle.
// ----------------------------------------------------------------------------
module x86_shift_rotate_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  x86sr_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output x86sr_pkg::out_item_t  out_data
);
  import x86sr_pkg::*;

  // Stage 1: request register
  in_item_t  req_r;
  in_item_t  req_nxt;
  logic      req_vld_r;
  logic      req_vld_nxt;

  // Stage 2: result register
  out_item_t rsp_r;
  out_item_t rsp_nxt;
  logic      rsp_vld_r;
  logic      rsp_vld_nxt;

  logic      adv1;
  logic      adv2;
  cnt_t      cnt;
  out_item_t alu_rsp;

  // A stage advances when it is empty or the stage after it advances
  assign adv2 = !rsp_vld_r || !out_stall;
  assign adv1 = !req_vld_r || adv2;
  assign in_stall = !adv1;

  x86sr_count u_count (
    .wide  (req_r.wide),
    .count (req_r.count),
    .cnt   (cnt)
  );

  x86sr_alu u_alu (
    .req (req_r),
    .cnt (cnt),
    .rsp (alu_rsp)
  );

  always_comb begin
    req_nxt     = adv1 ? in_data : req_r;
    req_vld_nxt = adv1 ? in_valid : req_vld_r;
    rsp_nxt     = adv2 ? alu_rsp : rsp_r;
    rsp_vld_nxt = adv2 ? req_vld_r : rsp_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_vld_r <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      req_vld_r <= req_vld_nxt;
      rsp_vld_r <= rsp_vld_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    rsp_r <= rsp_nxt;
  end

  assign out_valid = rsp_vld_r;
  assign out_data  = rsp_r;

`ifndef SYNTHESIS
  // An accepted request lands in the request register
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> req_vld_r)
    else $error("accepted request lost before stage 1");

  // A held request register keeps its contents
  a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r && in_stall |=> req_vld_r && $stable(req_r))
    else $error("stage 1 changed while stalled");

  // A request leaving stage 1 shows up as a result
  a_stage_move: assert property (@(posedge clk) disable iff (!rst_n)
    req_vld_r && !in_stall |=> out_valid)
    else $error("request dropped between stages");

  // Stalling happens only with both stages full
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> req_vld_r && rsp_vld_r && out_stall)
    else $error("stall raised with room in the pipeline");
`endif

endmodule

// ----- rtl/x86sr_count.sv -----
// ----------------------------------------------------------------------------
// x86sr_count: count reducer
// Reduces the raw 8-bit count modulo 8, 9, 16 and 17 and clamps it for the
// shifts. The odd moduli use digit folding instead of a divider.
// ----------------------------------------------------------------------------
module x86sr_count (
  input  logic             wide,
  input  logic [7:0]       count,
  output x86sr_pkg::cnt_t  cnt
);
  import x86sr_pkg::*;

  logic [3:0] hi17;
  logic [3:0] lo17;
  logic [4:0] m17;
  logic [6:0] s9;
  logic [3:0] c9;
  logic [3:0] d9;
  logic [3:0] m9;

  // 16 == -1 (mod 17): n mod 17 = lo - hi, corrected once
  assign hi17 = count[7:4];
  assign lo17 = count[3:0];
  assign m17  = (lo17 >= hi17) ? ({1'b0, lo17} - {1'b0, hi17})
                               : ({1'b0, lo17} + 5'd17 - {1'b0, hi17});

  // 64 == 1 (mod 9), then 8 == -1 (mod 9)
  assign s9 = {5'd0, count[7:6]} + {1'b0, count[5:0]};
  assign c9 = s9[6:3];
  assign d9 = {1'b0, s9[2:0]};
  assign m9 = (d9 >= c9) ? (d9 - c9) : (d9 + 4'd9 - c9);

  always_comb begin
    cnt.rot_r   = wide ? count[3:0] : {1'b0, count[2:0]};
    cnt.rc_r    = wide ? m17 : {1'b0, m9};
    if (wide) begin
      cnt.sh_amt = (count > 8'(WORD_W + 1)) ? 5'(WORD_W + 1) : count[4:0];
    end else begin
      cnt.sh_amt = (count > 8'(BYTE_W + 1)) ? 5'(BYTE_W + 1) : count[4:0];
    end
    cnt.is_zero = (count == 8'd0);
    cnt.is_one  = (count == 8'd1);
  end

endmodule

// ----- rtl/x86sr_alu.sv -----
// ----------------------------------------------------------------------------
// x86sr_alu: shift/rotate datapath
// Doubled-word barrel rotators for both widths, clamped shifters, and the
// flag logic. Purely combinational; sits between the stage registers.
// ----------------------------------------------------------------------------
module x86sr_alu (
  input  x86sr_pkg::in_item_t  req,
  input  x86sr_pkg::cnt_t      cnt,
  output x86sr_pkg::out_item_t rsp
);
  import x86sr_pkg::*;

  op_t         op;
  logic [7:0]  vb;
  logic [15:0] vw;
  logic [4:0]  rot_l;
  logic [4:0]  rc_l;
  logic [15:0] tb;
  logic [31:0] tw;
  logic [17:0] tbc;
  logic [33:0] twc;
  logic [8:0]  xb;
  logic [16:0] xw;
  logic [8:0]  shl_b;
  logic [16:0] shl_w;
  logic [8:0]  shr_b;
  logic [16:0] shr_w;
  logic [8:0]  sar_b;
  logic [16:0] sar_w;
  logic [15:0] res;
  logic        cf;
  logic        of;
  logic        msb;
  logic        nmsb;
  logic        vmsb;
  logic        is_shift;

  assign op = op_t'(req.op);
  assign vb = req.value[7:0];
  assign vw = req.wide ? req.value : {8'd0, vb};
  assign vmsb = req.wide ? req.value[15] : vb[7];

  // Right rotates are left rotates by (len - r)
  always_comb begin
    if (req.wide) begin
      rot_l = (op == OP_ROR) ? (5'(WORD_W) - {1'b0, cnt.rot_r}) : {1'b0, cnt.rot_r};
      rc_l  = (op == OP_RCR) ? (5'(WORD_W + 1) - cnt.rc_r) : cnt.rc_r;
    end else begin
      rot_l = (op == OP_ROR) ? (5'(BYTE_W) - {1'b0, cnt.rot_r}) : {1'b0, cnt.rot_r};
      rc_l  = (op == OP_RCR) ? (5'(BYTE_W + 1) - cnt.rc_r) : cnt.rc_r;
    end
  end

  assign tb  = {vb, vb} << rot_l;
  assign tw  = {req.value, req.value} << rot_l;
  assign tbc = {req.carry_in, vb, req.carry_in, vb} << rc_l;
  assign twc = {req.carry_in, req.value, req.carry_in, req.value} << rc_l;
  assign xb  = tbc[17:9];
  assign xw  = twc[33:17];

  // Shifters carry one extra bit for CF; amount clamped to width + 1
  assign shl_b = {1'b0, vb} << cnt.sh_amt;
  assign shl_w = {1'b0, req.value} << cnt.sh_amt;
  assign shr_b = {vb, 1'b0} >> cnt.sh_amt;
  assign shr_w = {req.value, 1'b0} >> cnt.sh_amt;
  assign sar_b = $unsigned($signed({vb, 1'b0}) >>> cnt.sh_amt);
  assign sar_w = $unsigned($signed({req.value, 1'b0}) >>> cnt.sh_amt);

  always_comb begin
    res = vw;
    cf  = req.carry_in;
    case (op)
      OP_ROL, OP_ROR: begin
        res = req.wide ? tw[31:16] : {8'd0, tb[15:8]};
      end
      OP_RCL, OP_RCR: begin
        res = req.wide ? xw[15:0] : {8'd0, xb[7:0]};
        cf  = req.wide ? xw[16] : xb[8];
      end
      OP_SHL: begin
        res = req.wide ? shl_w[15:0] : {8'd0, shl_b[7:0]};
        cf  = req.wide ? shl_w[16] : shl_b[8];
      end
      OP_SHR: begin
        res = req.wide ? shr_w[16:1] : {8'd0, shr_b[8:1]};
        cf  = req.wide ? shr_w[0] : shr_b[0];
      end
      OP_SAR: begin
        res = req.wide ? sar_w[16:1] : {8'd0, sar_b[8:1]};
        cf  = req.wide ? sar_w[0] : sar_b[0];
      end
      default: begin
        res = vw;
        cf  = req.carry_in;
      end
    endcase
  end

  assign msb  = req.wide ? res[15] : res[7];
  assign nmsb = req.wide ? res[14] : res[6];

  always_comb begin
    case (op)
      OP_ROL:  of = res[0] ^ msb;
      OP_ROR:  of = msb ^ nmsb;
      OP_RCL:  of = cf ^ msb;
      OP_RCR:  of = msb ^ nmsb;
      OP_SHL:  of = cf ^ msb;
      OP_SHR:  of = cnt.is_one & vmsb;
      default: of = 1'b0;
    endcase
  end

  assign is_shift = (op == OP_SHL) || (op == OP_SHR) || (op == OP_SAR);

  always_comb begin
    if (cnt.is_zero || (op == OP_NONE)) begin
      rsp.result       = vw;
      rsp.writes_back  = 1'b0;
      rsp.co_valid     = 1'b0;
      rsp.carry_out    = req.carry_in;
      rsp.overflow_out = 1'b0;
      rsp.szp_valid    = 1'b0;
      rsp.sign_out     = 1'b0;
      rsp.zero_out     = 1'b0;
      rsp.parity_out   = 1'b0;
    end else begin
      rsp.result       = res;
      rsp.writes_back  = 1'b1;
      rsp.co_valid     = 1'b1;
      rsp.carry_out    = ((op == OP_ROL) ? res[0] : ((op == OP_ROR) ? msb : cf));
      rsp.overflow_out = of;
      rsp.szp_valid    = is_shift;
      rsp.sign_out     = is_shift & msb;
      rsp.zero_out     = is_shift & (res == 16'd0);
      rsp.parity_out   = is_shift & ~(^res[7:0]);
    end
  end

endmodule
